// ===== rtl/pidc_pkg.sv =====
// shared constants and control types of the pid controller step
`default_nettype none

package pidc_pkg;

   // default datapath format
   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;

   // running integral width and configuration register width
   localparam int INTEG_WIDTH = 48;
   localparam int CFG_WIDTH   = 31;

   // stream and register port widths
   localparam int REQ_DATA_WIDTH = 64;
   localparam int RSP_DATA_WIDTH = 40;
   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 32;

   // pi with 48 fraction bits
   localparam logic [63:0] PI_Q48 = 64'h0003_243F_6A88_85A3;

   // request to the serial multiplier
   typedef struct packed {
      logic start;
      logic extra_shift;   // scale by one more fraction bit
      logic wide_range;    // saturate to the integral range
   } mul_ctrl_type;

   // report from the serial multiplier
   typedef struct packed {
      logic done;
      logic ovf;
   } mul_stat_type;

endpackage

`default_nettype wire

// ===== rtl/pid_controller_step.sv =====
// pid controller step: error, angle wrap, trapezoidal integral, derivative, clamp
// an accepted req word is worked through to rsp_tvalid one step at a time, and the next
//   req word is taken only after the result has gone to the output register
// the time taken is set by five products through one bit-serial multiplier, each working
//   through its 31 multiplier bits plus setup, rounding and saturation
// synchronous active-high reset returns the registers to their defaults and clears
//   the stored error, the integral and any result in flight
`default_nettype none

module pid_controller_step #(
   parameter int DATA_WIDTH = pidc_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = pidc_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // req_tdata: measured [31:0], target [63:32]
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [pidc_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,
   // rsp_tdata: drive [31:0], overflowed [32], zero [39:33]
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [pidc_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [pidc_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [pidc_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [pidc_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                 csr_pready
);
   import pidc_pkg::*;

   localparam int DW = DATA_WIDTH;
   localparam int IW = INTEG_WIDTH;
   localparam int AW = (DW + 1 > IW) ? DW + 1 : IW;
   localparam int XW = AW + 2;

   localparam logic signed [XW-1:0] DMAX = {{(XW-DW+1){1'b0}}, {(DW-1){1'b1}}};
   localparam logic signed [XW-1:0] DMIN = ~DMAX;
   localparam logic signed [XW-1:0] IMAX = {{(XW-IW+1){1'b0}}, {(IW-1){1'b1}}};
   localparam logic signed [XW-1:0] IMIN = ~IMAX;

   // pi and 2*pi rounded to nearest at the fraction width
   localparam logic [63:0] PI_HALF   = 64'd1 << (47 - FRAC_BITS);
   localparam logic [63:0] PI_FX     = (PI_Q48 + PI_HALF) >> (48 - FRAC_BITS);
   localparam logic [63:0] TWO_PI_FX = ((PI_Q48 << 1) + PI_HALF) >> (48 - FRAC_BITS);
   localparam logic signed [XW-1:0] PI_X     = XW'(PI_FX);
   localparam logic signed [XW-1:0] NEG_PI_X = -PI_X;
   localparam logic signed [XW-1:0] TWO_PI_X = XW'(TWO_PI_FX);

   // register indexes
   localparam logic [2:0] REG_SAMPLE_PERIOD  = 3'd0;
   localparam logic [2:0] REG_INVERSE_PERIOD = 3'd1;
   localparam logic [2:0] REG_GAIN_PROP      = 3'd2;
   localparam logic [2:0] REG_GAIN_INTEG     = 3'd3;
   localparam logic [2:0] REG_GAIN_DERIV     = 3'd4;
   localparam logic [2:0] REG_DRIVE_LIMIT    = 3'd5;
   localparam logic [2:0] REG_ANGULAR_MODE   = 3'd6;
   localparam logic [2:0] REG_CLAMP_ENABLE   = 3'd7;

   // products in issue order
   localparam logic [2:0] OP_DERIV = 3'd0;
   localparam logic [2:0] OP_INC   = 3'd1;
   localparam logic [2:0] OP_PROP  = 3'd2;
   localparam logic [2:0] OP_INTG  = 3'd3;
   localparam logic [2:0] OP_DTERM = 3'd4;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_ERR    = 4'd1;
   localparam logic [3:0] ST_WRAP   = 4'd2;
   localparam logic [3:0] ST_DIFF   = 4'd3;
   localparam logic [3:0] ST_LAUNCH = 4'd4;
   localparam logic [3:0] ST_WAIT   = 4'd5;
   localparam logic [3:0] ST_INTEG  = 4'd6;
   localparam logic [3:0] ST_SUM    = 4'd7;
   localparam logic [3:0] ST_TOTAL  = 4'd8;
   localparam logic [3:0] ST_CLAMP  = 4'd9;

   // configuration registers
   logic [CFG_WIDTH-1:0] sample_period_ff, inverse_period_ff;
   logic [CFG_WIDTH-1:0] gain_prop_ff, gain_integ_ff, gain_deriv_ff, drive_limit_ff;
   logic                 angular_mode_ff, clamp_enable_ff;
   logic                 csr_write;

   // control and state
   logic [3:0]           state_ff, state_in;
   logic [2:0]           op_ff, op_in;
   logic                 ovf_ff, ovf_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [DW-1:0] prev_ff, prev_in;
   logic signed [IW-1:0] integ_ff, integ_in;
   mul_ctrl_type         mul_ctrl_ff, mul_ctrl_in;

   // working values
   logic [31:0]          meas_ff, meas_in;
   logic [31:0]          targ_ff, targ_in;
   logic signed [DW-1:0] err_ff, err_in;
   logic signed [DW-1:0] diff_ff, diff_in;
   logic signed [DW-1:0] deriv_ff, deriv_in;
   logic signed [IW-1:0] inc_ff, inc_in;
   logic signed [DW-1:0] p_ff, p_in;
   logic signed [DW-1:0] i_ff, i_in;
   logic signed [DW-1:0] d_ff, d_in;
   logic signed [DW:0]   psum_ff, psum_in;
   logic signed [DW-1:0] u_ff, u_in;
   logic signed [AW-1:0] mul_a_ff, mul_a_in;
   logic [CFG_WIDTH-1:0] mul_b_ff, mul_b_in;
   logic [31:0]          drive_ff, drive_in;
   logic                 rsp_ovf_ff, rsp_ovf_in;

   // multiplier link
   logic signed [AW-1:0] mul_res;
   mul_stat_type         mul_stat;

   // widened views
   logic signed [XW-1:0] meas_x, targ_x, err_x, prev_x, diff_x, deriv_x;
   logic signed [XW-1:0] inc_x, integ_x, p_x, i_x, d_x, psum_x, u_x, lim_x, res_x;
   logic signed [XW-1:0] err_raw, diff_raw, integ_raw, total_raw, clamp_x;
   logic signed [XW-1:0] err_wrapped;
   logic                 out_free;

   assign meas_x  = {{(XW-32){meas_ff[31]}}, meas_ff};
   assign targ_x  = {{(XW-32){targ_ff[31]}}, targ_ff};
   assign err_x   = {{(XW-DW){err_ff[DW-1]}}, err_ff};
   assign prev_x  = {{(XW-DW){prev_ff[DW-1]}}, prev_ff};
   assign diff_x  = {{(XW-DW){diff_ff[DW-1]}}, diff_ff};
   assign deriv_x = {{(XW-DW){deriv_ff[DW-1]}}, deriv_ff};
   assign inc_x   = {{(XW-IW){inc_ff[IW-1]}}, inc_ff};
   assign integ_x = {{(XW-IW){integ_ff[IW-1]}}, integ_ff};
   assign p_x     = {{(XW-DW){p_ff[DW-1]}}, p_ff};
   assign i_x     = {{(XW-DW){i_ff[DW-1]}}, i_ff};
   assign d_x     = {{(XW-DW){d_ff[DW-1]}}, d_ff};
   assign psum_x  = {{(XW-DW-1){psum_ff[DW]}}, psum_ff};
   assign u_x     = {{(XW-DW){u_ff[DW-1]}}, u_ff};
   assign res_x   = {{(XW-AW){mul_res[AW-1]}}, mul_res};
   assign lim_x   = {{(XW-CFG_WIDTH){1'b0}}, drive_limit_ff};

   assign err_raw   = targ_x - meas_x;
   assign diff_raw  = err_x - prev_x;
   assign integ_raw = integ_x + inc_x;
   assign total_raw = psum_x + d_x;

   // angle wrap by one turn toward zero
   always_comb begin
      err_wrapped = err_x;
      if (err_x > PI_X) begin
         err_wrapped = err_x - TWO_PI_X;
      end else if (err_x < NEG_PI_X) begin
         err_wrapped = err_x + TWO_PI_X;
      end
   end

   // symmetric output clamp, applied when clamp_enable is set
   always_comb begin
      clamp_x = u_x;
      if (clamp_enable_ff) begin
         if (u_x > lim_x) begin
            clamp_x = lim_x;
         end else if (u_x < -lim_x) begin
            clamp_x = -lim_x;
         end
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   // step sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      prev_in      = prev_ff;
      integ_in     = integ_ff;
      mul_ctrl_in  = mul_ctrl_ff;
      mul_ctrl_in.start = 1'b0;
      meas_in      = meas_ff;
      targ_in      = targ_ff;
      err_in       = err_ff;
      diff_in      = diff_ff;
      deriv_in     = deriv_ff;
      inc_in       = inc_ff;
      p_in         = p_ff;
      i_in         = i_ff;
      d_in         = d_ff;
      psum_in      = psum_ff;
      u_in         = u_ff;
      mul_a_in     = mul_a_ff;
      mul_b_in     = mul_b_ff;
      drive_in     = drive_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               meas_in  = req_tdata[31:0];
               targ_in  = req_tdata[63:32];
               ovf_in   = 1'b0;
               state_in = ST_ERR;
            end
         end
         ST_ERR: begin
            if (err_raw > DMAX) begin
               err_in = DMAX[DW-1:0];
               ovf_in = 1'b1;
            end else if (err_raw < DMIN) begin
               err_in = DMIN[DW-1:0];
               ovf_in = 1'b1;
            end else begin
               err_in = err_raw[DW-1:0];
            end
            state_in = ST_WRAP;
         end
         ST_WRAP: begin
            if (angular_mode_ff) begin
               err_in = err_wrapped[DW-1:0];
            end
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            if (diff_raw > DMAX) begin
               diff_in = DMAX[DW-1:0];
               ovf_in  = 1'b1;
            end else if (diff_raw < DMIN) begin
               diff_in = DMIN[DW-1:0];
               ovf_in  = 1'b1;
            end else begin
               diff_in = diff_raw[DW-1:0];
            end
            op_in    = OP_DERIV;
            state_in = ST_LAUNCH;
         end
         ST_LAUNCH: begin
            mul_ctrl_in.start       = 1'b1;
            mul_ctrl_in.extra_shift = (op_ff == OP_INC);
            mul_ctrl_in.wide_range  = (op_ff == OP_INC);
            case (op_ff)
               OP_DERIV: begin
                  mul_a_in = diff_x[AW-1:0];
                  mul_b_in = inverse_period_ff;
               end
               OP_INC: begin
                  mul_a_in = AW'(err_x + prev_x);
                  mul_b_in = sample_period_ff;
               end
               OP_PROP: begin
                  mul_a_in = err_x[AW-1:0];
                  mul_b_in = gain_prop_ff;
               end
               OP_INTG: begin
                  mul_a_in = integ_x[AW-1:0];
                  mul_b_in = gain_integ_ff;
               end
               default: begin
                  mul_a_in = deriv_x[AW-1:0];
                  mul_b_in = gain_deriv_ff;
               end
            endcase
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (mul_stat.done) begin
               ovf_in = ovf_ff || mul_stat.ovf;
               case (op_ff)
                  OP_DERIV: deriv_in = res_x[DW-1:0];
                  OP_INC:   inc_in   = res_x[IW-1:0];
                  OP_PROP:  p_in     = res_x[DW-1:0];
                  OP_INTG:  i_in     = res_x[DW-1:0];
                  default:  d_in     = res_x[DW-1:0];
               endcase
               if (op_ff == OP_INC) begin
                  state_in = ST_INTEG;
               end else if (op_ff == OP_DTERM) begin
                  state_in = ST_SUM;
               end else begin
                  op_in    = op_ff + 3'd1;
                  state_in = ST_LAUNCH;
               end
            end
         end
         ST_INTEG: begin
            if (integ_raw > IMAX) begin
               integ_in = IMAX[IW-1:0];
               ovf_in   = 1'b1;
            end else if (integ_raw < IMIN) begin
               integ_in = IMIN[IW-1:0];
               ovf_in   = 1'b1;
            end else begin
               integ_in = integ_raw[IW-1:0];
            end
            op_in    = OP_PROP;
            state_in = ST_LAUNCH;
         end
         ST_SUM: begin
            psum_in  = (DW+1)'(p_x + i_x);
            state_in = ST_TOTAL;
         end
         ST_TOTAL: begin
            if (total_raw > DMAX) begin
               u_in   = DMAX[DW-1:0];
               ovf_in = 1'b1;
            end else if (total_raw < DMIN) begin
               u_in   = DMIN[DW-1:0];
               ovf_in = 1'b1;
            end else begin
               u_in = total_raw[DW-1:0];
            end
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            // wait here while the previous word still sits in the output register and is not being taken
            if (out_free) begin
               drive_in     = clamp_x[31:0];
               rsp_ovf_in   = ovf_ff;
               rsp_valid_in = 1'b1;
               prev_in      = err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_DERIV;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         prev_ff      <= '0;
         integ_ff     <= '0;
         mul_ctrl_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         prev_ff      <= prev_in;
         integ_ff     <= integ_in;
         mul_ctrl_ff  <= mul_ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      meas_ff    <= meas_in;
      targ_ff    <= targ_in;
      err_ff     <= err_in;
      diff_ff    <= diff_in;
      deriv_ff   <= deriv_in;
      inc_ff     <= inc_in;
      p_ff       <= p_in;
      i_ff       <= i_in;
      d_ff       <= d_in;
      psum_ff    <= psum_in;
      u_ff       <= u_in;
      mul_a_ff   <= mul_a_in;
      mul_b_ff   <= mul_b_in;
      drive_ff   <= drive_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   // shared serial multiplier
   pidc_mul #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS),
      .OPER_WIDTH (AW)
   ) u_mul (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (mul_ctrl_ff),
      .oper_a (mul_a_ff),
      .oper_b (mul_b_ff),
      .result (mul_res),
      .stat   (mul_stat)
   );

   // register writes
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_period_ff  <= CFG_WIDTH'(655);
         inverse_period_ff <= CFG_WIDTH'(6553600);
         gain_prop_ff      <= CFG_WIDTH'(65536);
         gain_integ_ff     <= '0;
         gain_deriv_ff     <= '0;
         drive_limit_ff    <= '1;
         angular_mode_ff   <= 1'b0;
         clamp_enable_ff   <= 1'b1;
      end else if (csr_write) begin
         case (csr_paddr[4:2])
            REG_SAMPLE_PERIOD:  sample_period_ff  <= csr_pwdata[CFG_WIDTH-1:0];
            REG_INVERSE_PERIOD: inverse_period_ff <= csr_pwdata[CFG_WIDTH-1:0];
            REG_GAIN_PROP:      gain_prop_ff      <= csr_pwdata[CFG_WIDTH-1:0];
            REG_GAIN_INTEG:     gain_integ_ff     <= csr_pwdata[CFG_WIDTH-1:0];
            REG_GAIN_DERIV:     gain_deriv_ff     <= csr_pwdata[CFG_WIDTH-1:0];
            REG_DRIVE_LIMIT:    drive_limit_ff    <= csr_pwdata[CFG_WIDTH-1:0];
            REG_ANGULAR_MODE:   angular_mode_ff   <= csr_pwdata[0];
            REG_CLAMP_ENABLE:   clamp_enable_ff   <= csr_pwdata[0];
            default: begin
            end
         endcase
      end
   end

   // register reads
   always_comb begin
      case (csr_paddr[4:2])
         REG_SAMPLE_PERIOD:  csr_prdata = {1'b0, sample_period_ff};
         REG_INVERSE_PERIOD: csr_prdata = {1'b0, inverse_period_ff};
         REG_GAIN_PROP:      csr_prdata = {1'b0, gain_prop_ff};
         REG_GAIN_INTEG:     csr_prdata = {1'b0, gain_integ_ff};
         REG_GAIN_DERIV:     csr_prdata = {1'b0, gain_deriv_ff};
         REG_DRIVE_LIMIT:    csr_prdata = {1'b0, drive_limit_ff};
         REG_ANGULAR_MODE:   csr_prdata = {31'd0, angular_mode_ff};
         REG_CLAMP_ENABLE:   csr_prdata = {31'd0, clamp_enable_ff};
         default:            csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;

   // stream ports
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_ovf_ff, drive_ff};

endmodule

`default_nettype wire

// ===== rtl/pidc_mul.sv =====
// bit-serial signed by unsigned multiplier with fraction scaling and saturation
`default_nettype none

module pidc_mul #(
   parameter int DATA_WIDTH = pidc_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = pidc_pkg::FRAC_BITS_DEF,
   parameter int OPER_WIDTH = (DATA_WIDTH + 1 > pidc_pkg::INTEG_WIDTH) ?
                              DATA_WIDTH + 1 : pidc_pkg::INTEG_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  pidc_pkg::mul_ctrl_type              ctrl,
   input  logic signed [OPER_WIDTH-1:0]        oper_a,
   input  logic [pidc_pkg::CFG_WIDTH-1:0]      oper_b,
   output logic signed [OPER_WIDTH-1:0]        result,
   output pidc_pkg::mul_stat_type              stat
);
   import pidc_pkg::*;

   localparam int AW = OPER_WIDTH;
   localparam int BW = CFG_WIDTH;
   localparam int PW = AW + BW;
   localparam int QW = PW - FRAC_BITS;
   localparam int CW = $clog2(BW);

   // largest positive results of the two ranges
   localparam logic [QW-1:0] HI_D = {{(QW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
   localparam logic [QW-1:0] HI_I = {{(QW-INTEG_WIDTH+1){1'b0}}, {(INTEG_WIDTH-1){1'b1}}};

   localparam logic [2:0] MS_IDLE = 3'd0;
   localparam logic [2:0] MS_ABS  = 3'd1;
   localparam logic [2:0] MS_RUN  = 3'd2;
   localparam logic [2:0] MS_RND  = 3'd3;
   localparam logic [2:0] MS_SAT  = 3'd4;

   logic [2:0]           mstate_ff, mstate_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic                 ovf_ff, ovf_in;
   logic signed [AW-1:0] a_ff, a_in;
   logic                 neg_ff, neg_in;
   logic                 extra_ff, extra_in;
   logic                 wide_ff, wide_in;
   logic [AW-1:0]        mag_ff, mag_in;
   logic [BW-1:0]        bsh_ff, bsh_in;
   logic [PW-1:0]        prod_ff, prod_in;
   logic [QW-1:0]        q_ff, q_in;
   logic signed [AW-1:0] res_ff, res_in;

   logic [AW-1:0] add_val;
   logic [AW:0]   upper_sum;
   logic [PW-1:0] prod_next;
   logic [QW-1:0] q_base;
   logic          rem_nz;
   logic [QW-1:0] q_round;
   logic [QW-1:0] lim_q;
   logic          sat_hit;
   logic [QW-1:0] mag_res;
   logic [AW-1:0] mag_t;

   // one multiplier bit per cycle: add into the upper half, then shift right
   assign add_val   = bsh_ff[0] ? mag_ff : '0;
   assign upper_sum = {1'b0, prod_ff[PW-1:BW]} + {1'b0, add_val};
   assign prod_next = {upper_sum, prod_ff[BW-1:1]};

   // floor scaling of the signed product, rounded away for negative operands
   assign q_base  = extra_ff ? QW'(prod_ff >> (FRAC_BITS + 1)) : prod_ff[PW-1:FRAC_BITS];
   assign rem_nz  = extra_ff ? (|prod_ff[FRAC_BITS:0]) : (|prod_ff[FRAC_BITS-1:0]);
   assign q_round = q_base + QW'(neg_ff && rem_nz);

   // magnitude limit, one more on the negative side
   assign lim_q   = (wide_ff ? HI_I : HI_D) + QW'(neg_ff);
   assign sat_hit = q_ff > lim_q;
   assign mag_res = sat_hit ? lim_q : q_ff;
   assign mag_t   = mag_res[AW-1:0];

   // sequencer of one product
   always_comb begin
      mstate_in = mstate_ff;
      cnt_in    = cnt_ff;
      done_in   = 1'b0;
      ovf_in    = ovf_ff;
      a_in      = a_ff;
      neg_in    = neg_ff;
      extra_in  = extra_ff;
      wide_in   = wide_ff;
      mag_in    = mag_ff;
      bsh_in    = bsh_ff;
      prod_in   = prod_ff;
      q_in      = q_ff;
      res_in    = res_ff;
      case (mstate_ff)
         MS_IDLE: begin
            if (ctrl.start) begin
               a_in      = oper_a;
               bsh_in    = oper_b;
               extra_in  = ctrl.extra_shift;
               wide_in   = ctrl.wide_range;
               mstate_in = MS_ABS;
            end
         end
         MS_ABS: begin
            neg_in    = a_ff[AW-1];
            mag_in    = a_ff[AW-1] ? AW'(-a_ff) : AW'(a_ff);
            prod_in   = '0;
            cnt_in    = CW'(BW - 1);
            mstate_in = MS_RUN;
         end
         MS_RUN: begin
            prod_in = prod_next;
            bsh_in  = bsh_ff >> 1;
            cnt_in  = cnt_ff - CW'(1);
            if (cnt_ff == '0) begin
               mstate_in = MS_RND;
            end
         end
         MS_RND: begin
            q_in      = q_round;
            mstate_in = MS_SAT;
         end
         MS_SAT: begin
            res_in    = neg_ff ? -$signed(mag_t) : $signed(mag_t);
            ovf_in    = sat_hit;
            done_in   = 1'b1;
            mstate_in = MS_IDLE;
         end
         default: begin
            mstate_in = MS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mstate_ff <= MS_IDLE;
         done_ff   <= 1'b0;
         ovf_ff    <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         mstate_ff <= mstate_in;
         done_ff   <= done_in;
         ovf_ff    <= ovf_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      neg_ff   <= neg_in;
      extra_ff <= extra_in;
      wide_ff  <= wide_in;
      mag_ff   <= mag_in;
      bsh_ff   <= bsh_in;
      prod_ff  <= prod_in;
      q_ff     <= q_in;
      res_ff   <= res_in;
   end

   assign result    = res_ff;
   assign stat.done = done_ff;
   assign stat.ovf  = ovf_ff;

endmodule

`default_nettype wire

// ===== rtl/pidc_checker.sv =====
// port-level checks of the pid controller step, bound to the top level
`default_nettype none

module pidc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [pidc_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   input logic                                csr_pready
);
   logic [1:0] open_ff, open_in;
   logic       req_take, rsp_take;

   assign req_take = req_tvalid && req_tready;
   assign rsp_take = rsp_tvalid && rsp_tready;

   // samples taken and not yet answered
   always_comb begin
      open_in = open_ff;
      if (req_take && !rsp_take) begin
         open_in = open_ff + 2'd1;
      end else if (rsp_take && !req_take) begin
         open_in = open_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_in;
      end
   end

   // one sample at a time: busy right after taking a word
   busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_take |=> !req_tready)
      else $error("req_tready stayed high after a word was taken");

   // no answer without a sample
   no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_take |-> open_ff != 2'd0)
      else $error("rsp word delivered with no sample outstanding");

   // at most one sample at work and one waiting in the output register
   bounded_open: assert property (@(posedge clock) disable iff (reset)
      open_ff != 2'd3)
      else $error("too many samples outstanding");

   // stalled result holds
   rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word changed while stalled");

   // reset empties the output and the register port is always ready
   reset_clean: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && csr_pready)
      else $error("output not empty after reset");

endmodule

bind pid_controller_step pidc_checker u_pidc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_pready (csr_pready)
);

`default_nettype wire
